>>> rtl/mmps_pkg.sv
// ----------------------------------------------------------------------------
// mmps_pkg
// shared state type and sequencer codes for the pair sum histogram block
// ----------------------------------------------------------------------------
package mmps_pkg;

    typedef logic [1:0] t_state;

    // sequencer codes
    localparam t_state ST_IDLE = 2'd0;  // waiting for an item
    localparam t_state ST_INS  = 2'd1;  // histogram update
    localparam t_state ST_LOAD = 2'd2;  // fetch first entries of both walks
    localparam t_state ST_WALK = 2'd3;  // greedy pairing, one step a cycle

endpackage

>>> rtl/min_max_pair_sum_histogram.sv
// ----------------------------------------------------------------------------
// min_max_pair_sum_histogram
// least possible maximum pair sum over two growing multisets
// ----------------------------------------------------------------------------
// Each item adds value_a to multiset A and value_b to multiset B (values above
// VALUE_MAX count as VALUE_MAX) and then reports the least possible maximum
// pair sum over all pairings of A with B. An item is taken when start is high
// and busy is low; the result shows on o_best_max_sum for one cycle with
// o_result_valid high and cannot be held off. The idle state reads the two
// histogram entries as the item is taken, the insert state writes them back,
// the load state fetches the first walk entries, then a single compare and
// subtract unit makes one greedy step a cycle, each step moving the low A
// pointer up or the high B pointer down. Both histograms clear at reset
// through per-entry valid flags, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module min_max_pair_sum_histogram #(
    parameter int VALUE_MAX = 100,
    parameter int MAX_ITEMS = 65535
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [6:0] i_value_a,
    input  logic [6:0] i_value_b,
    output logic       o_result_valid,
    output logic [7:0] o_best_max_sum
);

    localparam int DEPTH = VALUE_MAX + 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;   // entry address
    localparam int PW    = $clog2(VALUE_MAX + 2);             // walk pointer
    localparam int CW    = $clog2(MAX_ITEMS + 1);             // count width
    localparam int SW    = $clog2(2 * VALUE_MAX + 1);         // pair sum width

    // sequencer
    mmps_pkg::t_state r_state, n_state;

    // latched insert addresses
    logic [AW-1:0] r_ins_a, r_ins_b;

    // histogram stores and their valid flags
    logic [CW-1:0]    mem_a [DEPTH];
    logic [CW-1:0]    mem_b [DEPTH];
    logic [DEPTH-1:0] r_vld_a, r_vld_b;

    // registered read ports
    logic [CW-1:0] r_rd_a, r_rd_b;
    logic          r_rdv_a, r_rdv_b;
    logic [AW-1:0] rd_addr_a, rd_addr_b;
    logic [CW-1:0] rd_a, rd_b;

    // walk state: pointer lo into A, hi+1 into B, remaining counts
    logic [PW-1:0] r_lo, n_lo;
    logic [PW-1:0] r_hi_p1, n_hi_p1;
    logic [CW-1:0] r_rem_a, n_rem_a;
    logic [CW-1:0] r_rem_b, n_rem_b;
    logic          r_fresh_a, n_fresh_a;   // current A count is on the read port
    logic          r_fresh_b, n_fresh_b;
    logic [SW-1:0] r_best, n_best;

    logic          r_out_vld, n_out_vld;

    // step datapath
    logic [CW-1:0] cur_a, cur_b;
    logic          walk_done;
    logic          a_gt_b;
    logic [CW-1:0] sub_x, sub_y, sub_d;
    logic [SW-1:0] pair_sum;
    logic [AW-1:0] clamp_a, clamp_b;
    logic [CW-1:0] inc_a, inc_b;
    logic          wr_en;

    // clamp incoming values to the histogram range
    always_comb begin
        clamp_a = (int'(i_value_a) > VALUE_MAX) ? AW'(VALUE_MAX) : AW'(i_value_a);
        clamp_b = (int'(i_value_b) > VALUE_MAX) ? AW'(VALUE_MAX) : AW'(i_value_b);
    end

    // entries never written read as zero
    assign rd_a = r_rdv_a ? r_rd_a : '0;
    assign rd_b = r_rdv_b ? r_rd_b : '0;

    // saturating increment of the counts being inserted
    assign inc_a = (rd_a == CW'(MAX_ITEMS)) ? rd_a : rd_a + CW'(1);
    assign inc_b = (rd_b == CW'(MAX_ITEMS)) ? rd_b : rd_b + CW'(1);
    assign wr_en = (r_state == mmps_pkg::ST_INS);

    // current counts under the two pointers
    assign cur_a     = r_fresh_a ? rd_a : r_rem_a;
    assign cur_b     = r_fresh_b ? rd_b : r_rem_b;
    assign walk_done = (int'(r_lo) > VALUE_MAX) || (r_hi_p1 == '0);

    // shared compare and subtract: larger count minus smaller
    assign a_gt_b   = cur_a > cur_b;
    assign sub_x    = a_gt_b ? cur_a : cur_b;
    assign sub_y    = a_gt_b ? cur_b : cur_a;
    assign sub_d    = sub_x - sub_y;
    assign pair_sum = SW'(r_lo) + SW'(r_hi_p1 - PW'(1));

    // sequencer and walk step
    always_comb begin
        n_state   = r_state;
        n_lo      = r_lo;
        n_hi_p1   = r_hi_p1;
        n_rem_a   = r_rem_a;
        n_rem_b   = r_rem_b;
        n_fresh_a = r_fresh_a;
        n_fresh_b = r_fresh_b;
        n_best    = r_best;
        n_out_vld = 1'b0;
        unique case (r_state)
            mmps_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = mmps_pkg::ST_INS;
                end
            end
            mmps_pkg::ST_INS: begin
                n_state = mmps_pkg::ST_LOAD;
            end
            mmps_pkg::ST_LOAD: begin
                n_state   = mmps_pkg::ST_WALK;
                n_lo      = '0;
                n_hi_p1   = PW'(VALUE_MAX + 1);
                n_fresh_a = 1'b1;
                n_fresh_b = 1'b1;
                n_best    = '0;
            end
            mmps_pkg::ST_WALK: begin
                // keep whatever is current so a stale read port is not reused
                n_rem_a   = cur_a;
                n_rem_b   = cur_b;
                n_fresh_a = 1'b0;
                n_fresh_b = 1'b0;
                priority if (walk_done) begin
                    n_state   = mmps_pkg::ST_IDLE;
                    n_out_vld = 1'b1;
                end else if (cur_a == '0) begin
                    n_lo      = r_lo + PW'(1);
                    n_fresh_a = 1'b1;
                end else if (cur_b == '0) begin
                    n_hi_p1   = r_hi_p1 - PW'(1);
                    n_fresh_b = 1'b1;
                end else begin
                    if (pair_sum > r_best) begin
                        n_best = pair_sum;
                    end
                    if (a_gt_b) begin
                        // B run used up, A keeps the rest
                        n_rem_a   = sub_d;
                        n_hi_p1   = r_hi_p1 - PW'(1);
                        n_fresh_b = 1'b1;
                    end else begin
                        n_rem_b   = sub_d;
                        n_lo      = r_lo + PW'(1);
                        n_fresh_a = 1'b1;
                    end
                end
            end
            default: begin
                n_state = mmps_pkg::ST_IDLE;
            end
        endcase
    end

    // read addresses: insert entries, walk start, or next pointer
    always_comb begin
        rd_addr_a = '0;
        rd_addr_b = '0;
        unique case (r_state)
            mmps_pkg::ST_IDLE: begin
                rd_addr_a = clamp_a;
                rd_addr_b = clamp_b;
            end
            mmps_pkg::ST_LOAD: begin
                rd_addr_a = '0;
                rd_addr_b = AW'(VALUE_MAX);
            end
            mmps_pkg::ST_WALK: begin
                if (int'(n_lo) <= VALUE_MAX) begin
                    rd_addr_a = AW'(n_lo);
                end
                if (n_hi_p1 != '0) begin
                    rd_addr_b = AW'(n_hi_p1 - PW'(1));
                end
            end
            default: begin
                rd_addr_a = '0;
                rd_addr_b = '0;
            end
        endcase
    end

    // histogram stores
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_a[r_ins_a] <= inc_a;
            mem_b[r_ins_b] <= inc_b;
        end
        r_rd_a <= mem_a[rd_addr_a];
        r_rd_b <= mem_b[rd_addr_b];
    end

    // valid flags, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= '0;
            r_vld_b <= '0;
            r_rdv_a <= 1'b0;
            r_rdv_b <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld_a[r_ins_a] <= 1'b1;
                r_vld_b[r_ins_b] <= 1'b1;
            end
            r_rdv_a <= r_vld_a[rd_addr_a];
            r_rdv_b <= r_vld_b[rd_addr_b];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mmps_pkg::ST_IDLE;
            r_out_vld <= 1'b0;
            r_lo      <= '0;
            r_hi_p1   <= '0;
            r_fresh_a <= 1'b0;
            r_fresh_b <= 1'b0;
            r_best    <= '0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_lo      <= n_lo;
            r_hi_p1   <= n_hi_p1;
            r_fresh_a <= n_fresh_a;
            r_fresh_b <= n_fresh_b;
            r_best    <= n_best;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rem_a <= n_rem_a;
        r_rem_b <= n_rem_b;
        if (r_state == mmps_pkg::ST_IDLE) begin
            r_ins_a <= clamp_a;
            r_ins_b <= clamp_b;
        end
    end

    assign busy           = (r_state != mmps_pkg::ST_IDLE);
    assign o_result_valid = r_out_vld;
    assign o_best_max_sum = 8'(r_best);

    // an accepted item keeps the block busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not make the block busy");

    // a result only follows the end of a walk
    a_result_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ($past(r_state) == mmps_pkg::ST_WALK) && !busy)
        else $error("result strobe outside the end of a walk");

    // pointers never run past their end markers
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mmps_pkg::ST_WALK) |->
            (int'(r_lo) <= VALUE_MAX + 1) && (int'(r_hi_p1) <= VALUE_MAX + 1))
        else $error("walk pointer out of range");

    // the best sum never exceeds the largest possible pair
    a_best_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_best) <= 2 * VALUE_MAX)
        else $error("best pair sum out of range");

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the least maximum pair sum histogram block
// ----------------------------------------------------------------------------
// A driver fed from a queue of pending items presents value pairs on the
// start/busy handshake. It keeps its own count histograms of both multisets
// and, on every item taken, re-runs the greedy low-A / high-B pairing to
// predict the reported sum. A monitor compares each strobed result with the
// oldest prediction. Directed pairs cover the field extremes and values
// above the histogram range. Random pairs follow, with sender gaps that
// change by phase and a few items held back until all results are in.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int HIST_MAX    = 100;      // top histogram bin
    localparam int COUNT_SAT   = 65535;    // per-bin count ceiling
    localparam int RAND_ITEMS  = 750;
    localparam int PHASE_LEN   = 96;       // items per idling phase
    localparam int DRAIN_EVERY = 180;      // random items between full drains
    localparam int TAIL_CYCLES = 250;      // beyond the worst item latency
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [6:0] val_a;
        logic [6:0] val_b;
        bit         drain;   // hold until every prediction has been matched
    } t_pair_item;

    logic       i_clk;
    logic       i_rst_n     = 1'b0;
    logic       start       = 1'b0;
    logic       busy;
    logic [6:0] i_value_a   = '0;
    logic [6:0] i_value_b   = '0;
    logic       o_result_valid;
    logic [7:0] o_best_max_sum;

    // items still to be presented, and sums predicted but not yet seen
    t_pair_item pair_queue[$];
    logic [7:0] best_sums_due[$];

    // predictor copy of both count histograms
    logic [15:0] hist_a [0:HIST_MAX] = '{default: '0};
    logic [15:0] hist_b [0:HIST_MAX] = '{default: '0};

    int items_taken = 0;
    int failures    = 0;
    int cycle_count = 0;

    min_max_pair_sum_histogram dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_value_a      (i_value_a),
        .i_value_b      (i_value_b),
        .o_result_valid (o_result_valid),
        .o_best_max_sum (o_best_max_sum)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // random value: mostly in range, some above the top bin, some near the
    // ends, some repeats to build runs of equal values
    function automatic logic [6:0] pick_value(logic [6:0] prev);
        int mode;
        mode = $urandom_range(99, 0);
        if (mode < 65) begin
            return 7'($urandom_range(HIST_MAX, 0));
        end else if (mode < 75) begin
            return 7'($urandom_range(127, HIST_MAX + 1));
        end else if (mode < 80) begin
            return 7'($urandom_range(3, 0));
        end else if (mode < 85) begin
            return 7'($urandom_range(HIST_MAX, HIST_MAX - 3));
        end else begin
            return prev;
        end
    endfunction

    // ------------------------------------------------------------------------
    // driver: on each item taken, update the histograms and predict the sum,
    // then decide whether to offer the next item this cycle
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : driver
        int          lo;
        int          hi;
        int          best;
        int          idle_pct;
        logic [6:0]  va;
        logic [6:0]  vb;
        logic [15:0] wa [0:HIST_MAX];
        logic [15:0] wb [0:HIST_MAX];
        logic        offer;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            offer = !start;
            if (start && !busy) begin
                // values above the top bin land in the top bin
                va = (i_value_a > HIST_MAX) ? 7'(HIST_MAX) : i_value_a;
                vb = (i_value_b > HIST_MAX) ? 7'(HIST_MAX) : i_value_b;
                if (hist_a[va] < COUNT_SAT) hist_a[va] = hist_a[va] + 1'b1;
                if (hist_b[vb] < COUNT_SAT) hist_b[vb] = hist_b[vb] + 1'b1;

                // greedy pairing on working copies: smallest A with largest B,
                // consuming whole runs of equal values at a time
                wa   = hist_a;
                wb   = hist_b;
                lo   = 0;
                hi   = HIST_MAX;
                best = 0;
                while (lo <= HIST_MAX && hi >= 0) begin
                    if (wa[lo] == 0) begin
                        lo++;
                    end else if (wb[hi] == 0) begin
                        hi--;
                    end else begin
                        if (lo + hi > best) best = lo + hi;
                        if (wa[lo] > wb[hi]) begin
                            wa[lo] = wa[lo] - wb[hi];
                            wb[hi] = '0;
                            hi--;
                        end else begin
                            wb[hi] = wb[hi] - wa[lo];
                            wa[lo] = '0;
                            lo++;
                        end
                    end
                end
                best_sums_due.push_back(best[7:0]);
                items_taken++;
                offer = 1'b1;
            end

            // start is assigned once per edge, and only when not holding an item
            if (offer) begin
                case ((items_taken / PHASE_LEN) % 4)
                    1:       idle_pct = 60;
                    3:       idle_pct = 20;
                    default: idle_pct = 0;
                endcase
                if (pair_queue.size() > 0
                        && !(pair_queue[0].drain && best_sums_due.size() > 0)
                        && $urandom_range(99, 0) >= idle_pct) begin
                    start     <= 1'b1;
                    i_value_a <= pair_queue[0].val_a;
                    i_value_b <= pair_queue[0].val_b;
                    void'(pair_queue.pop_front());
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: every strobed result must match the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        logic [7:0] want;
        if (i_rst_n && o_result_valid) begin
            if (best_sums_due.size() == 0) begin
                $error("best_max_sum: no result expected, actual %0d", o_best_max_sum);
                failures++;
            end else begin
                want = best_sums_due.pop_front();
                if (o_best_max_sum !== want) begin
                    $error("best_max_sum: expected %0d, actual %0d", want, o_best_max_sum);
                    failures++;
                end
            end
        end
    end

    // run-length guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial begin : main
        t_pair_item it;
        logic [6:0] last_a;
        logic [6:0] last_b;

        // directed pairs: first item alone, both extremes, values above the
        // top bin on each side, alternating bit patterns, equal runs
        pair_queue.push_back('{7'd0,   7'd0,   1'b0});
        pair_queue.push_back('{7'd100, 7'd100, 1'b0});
        pair_queue.push_back('{7'd127, 7'd127, 1'b0});
        pair_queue.push_back('{7'd101, 7'd0,   1'b0});
        pair_queue.push_back('{7'd0,   7'd101, 1'b0});
        pair_queue.push_back('{7'd85,  7'd42,  1'b0});
        pair_queue.push_back('{7'd42,  7'd85,  1'b0});
        pair_queue.push_back('{7'd64,  7'd63,  1'b0});
        pair_queue.push_back('{7'd63,  7'd64,  1'b0});
        pair_queue.push_back('{7'd1,   7'd1,   1'b1});
        pair_queue.push_back('{7'd100, 7'd0,   1'b0});
        pair_queue.push_back('{7'd0,   7'd100, 1'b0});
        pair_queue.push_back('{7'd50,  7'd50,  1'b0});
        pair_queue.push_back('{7'd50,  7'd50,  1'b0});
        pair_queue.push_back('{7'd99,  7'd1,   1'b0});
        pair_queue.push_back('{7'd2,   7'd98,  1'b0});
        pair_queue.push_back('{7'd120, 7'd7,   1'b0});
        pair_queue.push_back('{7'd7,   7'd120, 1'b0});
        pair_queue.push_back('{7'd127, 7'd0,   1'b0});
        pair_queue.push_back('{7'd0,   7'd127, 1'b1});

        last_a = '0;
        last_b = '0;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            it.val_a = pick_value(last_a);
            it.val_b = pick_value(last_b);
            it.drain = (n % DRAIN_EVERY) == DRAIN_EVERY - 1;
            last_a   = it.val_a;
            last_b   = it.val_b;
            pair_queue.push_back(it);
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all items taken and all predictions matched
        do @(posedge i_clk);
        while (pair_queue.size() > 0 || start || best_sums_due.size() > 0);

        // watch for stray results past the last one
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (failures == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
